/* hw/rtl/b64c_pkg.sv */
// Base64 stream codec: shared types, constants and alphabet mapping functions.
// No dependencies; every other file of the codec imports this package.

package b64c_pkg;

	localparam int BYTE_W      = 8;
	localparam int GROUP_W     = 24;
	localparam int SEXTET_W    = 6;
	localparam int GROUP_MAX   = 4;
	localparam int CNT_W       = 2;
	localparam int NUM_W       = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 1;
	localparam int Q_DEPTH_DEF = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_URL_ALPHABET = 1'b1;

	localparam logic [BYTE_W-1:0] CH_PAD       = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_UPPER_A   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_Z   = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LOWER_A   = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOWER_Z   = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_DIGIT_0   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIGIT_9   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_PLUS      = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_MINUS     = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_UNDERLINE = 8'h5F;

	// one queued run: up to four output words of a single accepted item
	typedef struct packed {
		logic [GROUP_MAX-1:0][BYTE_W-1:0] data;
		logic [NUM_W-1:0]                 num;
		logic                             eom;
	} job_t;

	function automatic logic [BYTE_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] v,
			input logic url);
		logic [BYTE_W-1:0] c;
		logic [BYTE_W-1:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			c = CH_UPPER_A + w;
		else if (v < 6'd52)
			c = CH_LOWER_A + (w - 8'd26);
		else if (v < 6'd62)
			c = CH_DIGIT_0 + (w - 8'd52);
		else if (v == 6'd62)
			c = url ? CH_MINUS : CH_PLUS;
		else
			c = url ? CH_UNDERLINE : CH_SLASH;
		return c;
	endfunction

	function automatic logic [SEXTET_W-1:0] char_to_sextet(input logic [BYTE_W-1:0] c,
			input logic url);
		logic [BYTE_W-1:0] s;
		s = 8'd0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			s = c - CH_UPPER_A;
		else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			s = c - CH_LOWER_A + 8'd26;
		else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
			s = c - CH_DIGIT_0 + 8'd52;
		else if (url && c == CH_MINUS)
			s = 8'd62;
		else if (url && c == CH_UNDERLINE)
			s = 8'd63;
		else if (!url && c == CH_PLUS)
			s = 8'd62;
		else if (!url && c == CH_SLASH)
			s = 8'd63;
		return s[SEXTET_W-1:0];
	endfunction

endpackage

/* hw/rtl/b64c_ifs.sv */
// Base64 stream codec: valid/ready channel interfaces for items, results, config.
// Depends on b64c_pkg.

interface b64c_item_if import b64c_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              has_byte;
	logic              end_of_message;

	modport source(output valid, in_byte, has_byte, end_of_message, input ready);
	modport sink(input valid, in_byte, has_byte, end_of_message, output ready);
endinterface

interface b64c_result_if import b64c_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_run;
	logic              message_done;

	modport source(output valid, out_byte, last_of_run, message_done, input ready);
	modport sink(input valid, out_byte, last_of_run, message_done, output ready);
endinterface

interface b64c_cfg_if import b64c_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/base64_stream_codec.sv */
// Base64 stream codec top level: front end, run queue and back end.
// Depends on b64c_pkg, b64c_ifs, b64c_front, b64c_queue, b64c_back.
//
//   channel  role  word carries
//   item     sink  in_byte, has_byte, end_of_message
//   result   src   out_byte, last_of_run, message_done
//   cfg      sink  index, data (0 decode_mode, 1 url_alphabet), always ready
//
// An item is taken when item.ready is high, and its run of 0 to 4 words leaves at one word per cycle
// while result.ready is high, so the output port sets the pace. The first word passes through
// the queue, the run register and the output register. Reset clears config, group state and queue.
// A full queue drops item.ready; a stalled result port holds its word and backs up the queue.

module base64_stream_codec import b64c_pkg::*; #(
	parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	b64c_item_if.sink     item,
	b64c_result_if.source result,
	b64c_cfg_if.sink      cfg
);

	logic q_full;
	logic q_nonempty;
	logic push;
	logic pop;
	job_t push_job;
	job_t q_head;

	b64c_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	b64c_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	b64c_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* hw/rtl/b64c_front.sv */
// Base64 stream codec front end: config registers, group state, run building.
// Depends on b64c_pkg and b64c_ifs.

module b64c_front import b64c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	b64c_item_if.sink   item,
	b64c_cfg_if.sink    cfg,
	input  logic        q_full,
	output logic        push,
	output job_t        push_job
);

	logic               decode_mode_q;
	logic               url_alphabet_q;
	logic [GROUP_W-1:0] group_bits_q;
	logic [CNT_W-1:0]   group_count_q;
	logic               pad_seen_q;

	logic               accept;
	logic               cfg_wr;
	logic [GROUP_W-1:0] enc_bits;
	logic [GROUP_W-1:0] dec_bits;
	logic [GROUP_W-1:0] a_bits;
	logic [NUM_W-1:0]   a_cnt;
	logic               a_pad;
	logic               full;
	logic [SEXTET_W-1:0] sx;
	logic [GROUP_W-1:0] nx_bits;
	logic [CNT_W-1:0]   nx_cnt;
	logic               nx_pad;
	logic               gen;

	assign item.ready = !q_full;
	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && item.ready;
	assign cfg_wr     = cfg.valid && cfg.ready;
	assign sx         = char_to_sextet(item.in_byte, url_alphabet_q);

	always_comb begin
		enc_bits = group_bits_q;
		dec_bits = group_bits_q;
		unique case (group_count_q)
			2'd0: begin
				enc_bits[23:16] = group_bits_q[23:16] | item.in_byte;
				dec_bits[23:18] = group_bits_q[23:18] | sx;
			end
			2'd1: begin
				enc_bits[15:8]  = group_bits_q[15:8] | item.in_byte;
				dec_bits[17:12] = group_bits_q[17:12] | sx;
			end
			2'd2: begin
				enc_bits[7:0]   = group_bits_q[7:0] | item.in_byte;
				dec_bits[11:6]  = group_bits_q[11:6] | sx;
			end
			2'd3: begin
				enc_bits[7:0]   = group_bits_q[7:0] | item.in_byte;
				dec_bits[5:0]   = group_bits_q[5:0] | sx;
			end
		endcase
	end

	always_comb begin
		a_bits   = group_bits_q;
		a_cnt    = {1'b0, group_count_q};
		a_pad    = pad_seen_q;
		full     = 1'b0;
		gen      = 1'b0;
		push_job = '0;
		push_job.eom = item.end_of_message;
		if (!decode_mode_q) begin
			if (item.has_byte) begin
				a_bits = enc_bits;
				a_cnt  = {1'b0, group_count_q} + 3'd1;
			end
			full = (a_cnt == 3'd3);
			for (int k = 0; k < GROUP_MAX; k++) begin
				push_job.data[k] = sextet_to_char(a_bits[GROUP_W-1-SEXTET_W*k -: SEXTET_W],
					url_alphabet_q);
				if (!url_alphabet_q && NUM_W'(k) > a_cnt)
					push_job.data[k] = CH_PAD;
			end
			if (full) begin
				gen          = 1'b1;
				push_job.num = 3'd4;
			end else if (item.end_of_message && a_cnt != 3'd0) begin
				gen          = 1'b1;
				push_job.num = url_alphabet_q ? a_cnt + 3'd1 : 3'd4;
			end
		end else begin
			if (item.has_byte && !pad_seen_q) begin
				if (item.in_byte == CH_PAD) begin
					a_pad = 1'b1;
				end else begin
					a_bits = dec_bits;
					a_cnt  = {1'b0, group_count_q} + 3'd1;
				end
			end
			full = (a_cnt == 3'd4);
			for (int k = 0; k < GROUP_MAX - 1; k++)
				push_job.data[k] = a_bits[GROUP_W-1-BYTE_W*k -: BYTE_W];
			if (full) begin
				gen          = 1'b1;
				push_job.num = 3'd3;
			end else if (item.end_of_message && a_cnt >= 3'd2) begin
				gen          = 1'b1;
				push_job.num = a_cnt - 3'd1;
			end
		end

		nx_bits = a_bits;
		nx_cnt  = a_cnt[CNT_W-1:0];
		nx_pad  = a_pad;
		if (item.end_of_message) begin
			nx_bits = '0;
			nx_cnt  = '0;
			nx_pad  = 1'b0;
		end else if (full) begin
			nx_bits = '0;
			nx_cnt  = '0;
		end
	end

	assign push = accept && gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q  <= 1'b0;
			url_alphabet_q <= 1'b0;
			group_bits_q   <= '0;
			group_count_q  <= '0;
			pad_seen_q     <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				CFG_DECODE_MODE:  decode_mode_q  <= cfg.data[0];
				CFG_URL_ALPHABET: url_alphabet_q <= cfg.data[0];
			endcase
			group_bits_q  <= '0;
			group_count_q <= '0;
			pad_seen_q    <= 1'b0;
		end else if (accept) begin
			group_bits_q  <= nx_bits;
			group_count_q <= nx_cnt;
			pad_seen_q    <= nx_pad;
		end
	end

endmodule

/* hw/rtl/b64c_queue.sv */
// Base64 stream codec run queue: small register FIFO between front and back.
// Depends on b64c_pkg.

module b64c_queue import b64c_pkg::*; #(
	parameter int DEPTH = Q_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output job_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int QC_W  = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QC_W-1:0]  count_q;
	logic             do_pop;

	assign full     = (count_q == QC_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* hw/rtl/b64c_back.sv */
// Base64 stream codec back end: serializes queued runs into an output register.
// Depends on b64c_pkg and b64c_ifs.

module b64c_back import b64c_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_nonempty,
	input  job_t         q_head,
	output logic         pop,
	b64c_result_if.source result
);

	job_t             job_q;
	logic             job_vld_q;
	logic [CNT_W-1:0] idx_q;
	logic             out_vld_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic             out_last_q;
	logic             out_done_q;

	logic adv;
	logic emit;
	logic last;
	logic job_free;

	assign adv      = !out_vld_q || result.ready;
	assign emit     = adv && job_vld_q;
	assign last     = ({1'b0, idx_q} + 3'd1) == job_q.num;
	assign job_free = !job_vld_q || (emit && last);
	assign pop      = job_free && q_nonempty;

	assign result.valid        = out_vld_q;
	assign result.out_byte     = out_byte_q;
	assign result.last_of_run  = out_last_q;
	assign result.message_done = out_done_q;

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= q_head;
		if (emit) begin
			out_byte_q <= job_q.data[idx_q];
			out_last_q <= last;
			out_done_q <= last && job_q.eom;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				job_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (emit && last) begin
				job_vld_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (adv)
				out_vld_q <= job_vld_q;
		end
	end

endmodule
